FILE: design/clic_pkg.sv
// Package for the core-local interrupt controller.
// Request/result structs, register map constants and sizes. No dependencies.
package clic_pkg;

    localparam int NumInts  = 64;
    localparam int NumTrigs = 32;
    localparam int RegionBytes = 65536;
    localparam int IdW   = $clog2(NumInts);
    localparam int TrigW = $clog2(NumTrigs);

    localparam logic [16:0] TrigBase  = 17'h0040;
    localparam logic [16:0] TrigEnd   = 17'h00C0;
    localparam logic [16:0] TableBase = 17'h1000;
    localparam logic [16:0] TableEnd  = 17'h5000;

    localparam logic [1:0] ActRead  = 2'd0;
    localparam logic [1:0] ActWrite = 2'd1;
    localparam logic [1:0] ActEval  = 2'd2;

    localparam int QDepth = 2;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] address;
        logic [1:0]  size_code;
        logic [31:0] wdata;
        logic [1:0]  cur_priv;
        logic [7:0]  cur_level;
        logic [7:0]  cur_thresh;
        logic        global_ie;
    } req_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic        access_ok;
        logic        int_taken;
        logic        int_vertical;
        logic [11:0] int_id;
        logic [1:0]  int_priv;
        logic [7:0]  int_level;
        logic        wake;
    } rsp_t;

    // Decoded request class handed from the front to the back
    typedef enum logic [2:0] {
        CL_NONE, CL_RSV, CL_TRIG, CL_TABLE, CL_ABOVE, CL_EVAL
    } cls_t;

    typedef struct packed {
        cls_t  cls;
        req_t  req;
        logic  wr;
        logic  ok_pre;   // precomputed access_ok for simple classes
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_ACC, ST_SCAN, ST_EN, ST_DONE
    } state_t;

endpackage

FILE: design/clic_front.sv
// Front end: accepts requests, classifies address regions, feeds a small queue.
// Depends on clic_pkg.
module clic_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  clic_pkg::req_t  in_data,
    output logic            q_valid,
    input  logic            q_pop,
    output clic_pkg::cmd_t  q_data
);
    import clic_pkg::*;

    cmd_t cmd;
    cmd_t q_reg [QDepth];
    logic [0:0] wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic [16:0] a, a_end;
    logic push;

    // Region classification by starting address
    always_comb
    begin
        a = {1'b0, in_data.address};
        a_end = a + (17'd1 << in_data.size_code);
        cmd.req = in_data;
        cmd.wr = (in_data.action == ActWrite);
        cmd.ok_pre = 1'b0;
        cmd.cls = CL_NONE;
        if (in_data.action == ActEval)
            cmd.cls = CL_EVAL;
        else if ((in_data.action == ActRead || in_data.action == ActWrite)
                 && in_data.size_code != 2'd3)
        begin
            if (a < TrigBase || (a >= TrigEnd && a < TableBase))
            begin
                cmd.cls = CL_RSV;
                cmd.ok_pre = !cmd.wr;
            end
            else if (a < TrigEnd)
                cmd.cls = CL_TRIG;
            else if (a < TableEnd)
                cmd.cls = CL_TABLE;
            else
            begin
                cmd.cls = CL_ABOVE;
                cmd.ok_pre = (a_end <= 17'(RegionBytes));
            end
        end
    end

    assign in_stall = (cnt_reg == 2'(QDepth));
    assign push = in_valid && !in_stall;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= cmd;
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (q_pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

endmodule

FILE: design/clic_back.sv
// Back end: table RAMs, access execution and the sequential priority scan.
// Also holds clic_ram, the generic RAM used for the table. Depends on clic_pkg.

// Generic RAM: one write port, one read port with registered data
module clic_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem_reg [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

module clic_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shv_enabled,
    input  logic            q_valid,
    output logic            q_pop,
    input  clic_pkg::cmd_t  q_data,
    output logic            out_valid,
    input  logic            out_stall,
    output clic_pkg::rsp_t  out_data
);
    import clic_pkg::*;

    logic [31:0] trig_reg [NumTrigs];

    state_t state_reg, state_next;
    logic [IdW:0]   scan_reg;
    logic [IdW-1:0] clr_reg;
    logic [9:0]  best_reg;
    logic [11:0] id_reg;
    logic [1:0]  bpriv_reg;
    logic [7:0]  blevel_reg;
    rsp_t rsp_reg, acc_rsp, eval_rsp;
    logic ovalid_reg;

    req_t r;
    logic [15:0] idx_full;
    logic [IdW-1:0] tab_idx, tab_raddr, en_raddr, ram_waddr;
    logic [1:0]  off;
    logic [2:0]  len;
    logic [IdW-1:0] scan_idx;
    logic [9:0]  key;
    logic        start, is_acc, out_free, tab_we, trig_we;
    logic [3:0]  lane_we;
    logic [3:0][7:0] lane_wd;
    logic [3:0]  ram_we;
    logic [3:0][7:0] ram_wd;
    logic [7:0]  pend_rd, en_rd, attr_rd, ctl_rd;
    logic [7:0]  lvl;
    logic        en, ie;

    assign r = q_data.req;
    assign len = 3'd1 << r.size_code;
    assign off = r.address[1:0];
    assign scan_idx = scan_reg[IdW-1:0];
    assign key = {attr_rd[7:6], ctl_rd};
    assign is_acc = (q_data.cls != CL_EVAL);
    assign out_free = !(ovalid_reg && out_stall);
    assign idx_full = (r.address - ((q_data.cls == CL_TRIG) ? 16'(TrigBase)
                                                            : 16'(TableBase))) >> 2;
    assign tab_idx = idx_full[IdW-1:0];
    assign start = q_valid && state_reg == ST_IDLE && out_free;
    assign tab_we = start && is_acc && q_data.wr && q_data.cls == CL_TABLE
                    && idx_full < 16'(NumInts);
    assign trig_we = start && is_acc && q_data.wr && q_data.cls == CL_TRIG
                     && idx_full < 16'(NumTrigs);

    // Write bytes steered onto their lanes; bytes past the word are dropped
    always_comb
    begin
        lane_we = '0;
        lane_wd = '0;
        for (int i = 0; i < 4; i++)
            if (3'(i) < len && 3'(off) + 3'(i) <= 3'd3)
            begin
                lane_we[off + 2'(i)] = 1'b1;
                lane_wd[off + 2'(i)] = r.wdata[8*i +: 8];
            end
    end

    // Table RAM ports: clearing pass after reset, then access writes
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we = 4'hF;
            ram_waddr = clr_reg;
            ram_wd = '0;
        end
        else
        begin
            ram_we = tab_we ? lane_we : 4'h0;
            ram_waddr = tab_idx;
            ram_wd = lane_wd;
            ram_wd[2][0] = lane_wd[2][0] & shv_enabled;
        end
        tab_raddr = (state_reg == ST_SCAN) ? scan_idx : tab_idx;
        en_raddr = (state_reg == ST_EN) ? id_reg[IdW-1:0] : tab_idx;
    end

    clic_ram #(.Width(8), .Depth(NumInts)) u_pend_ram (
        .clk   (clk),
        .we    (ram_we[0]),
        .waddr (ram_waddr),
        .wdata (ram_wd[0]),
        .raddr (tab_raddr),
        .rdata (pend_rd)
    );

    clic_ram #(.Width(8), .Depth(NumInts)) u_en_ram (
        .clk   (clk),
        .we    (ram_we[1]),
        .waddr (ram_waddr),
        .wdata (ram_wd[1]),
        .raddr (en_raddr),
        .rdata (en_rd)
    );

    clic_ram #(.Width(8), .Depth(NumInts)) u_attr_ram (
        .clk   (clk),
        .we    (ram_we[2]),
        .waddr (ram_waddr),
        .wdata (ram_wd[2]),
        .raddr (tab_raddr),
        .rdata (attr_rd)
    );

    clic_ram #(.Width(8), .Depth(NumInts)) u_ctl_ram (
        .clk   (clk),
        .we    (ram_we[3]),
        .waddr (ram_waddr),
        .wdata (ram_wd[3]),
        .raddr (tab_raddr),
        .rdata (ctl_rd)
    );

    // Access path: read data and status, taken from the registered RAM read data
    always_comb
    begin
        acc_rsp = '0;
        case (q_data.cls)
            CL_RSV, CL_ABOVE: acc_rsp.access_ok = q_data.ok_pre;
            CL_TRIG:
            begin
                acc_rsp.access_ok = 1'b1;
                for (int i = 0; i < 4; i++)
                    if (3'(i) < len && 3'(off) + 3'(i) <= 3'd3
                        && idx_full < 16'(NumTrigs))
                        acc_rsp.rdata[8*i +: 8] =
                            trig_reg[idx_full[TrigW-1:0]][8*(off+2'(i)) +: 8];
            end
            CL_TABLE:
            begin
                if (q_data.wr || 3'(off) + len <= 3'd4)
                begin
                    acc_rsp.access_ok = 1'b1;
                    if (!q_data.wr && idx_full < 16'(NumInts))
                        for (int i = 0; i < 4; i++)
                            if (3'(i) < len)
                                case (off + 2'(i))
                                    2'd0: acc_rsp.rdata[8*i +: 8] = pend_rd;
                                    2'd1: acc_rsp.rdata[8*i +: 8] = en_rd;
                                    2'd2: acc_rsp.rdata[8*i +: 8] = attr_rd;
                                    default: acc_rsp.rdata[8*i +: 8] = ctl_rd;
                                endcase
                end
            end
            default: ;
        endcase
        if (q_data.wr)
            acc_rsp.rdata = '0;
    end

    // Take decision after the scan
    always_comb
    begin
        eval_rsp = '0;
        eval_rsp.int_id = id_reg;
        eval_rsp.int_priv = bpriv_reg;
        eval_rsp.int_level = blevel_reg;
        en = (en_rd != 8'd0);
        lvl = (r.cur_level < r.cur_thresh) ? r.cur_thresh : r.cur_level;
        ie = (r.cur_priv != 2'd2) && r.global_ie && en;
        if (blevel_reg != 8'd0)
        begin
            eval_rsp.wake = en;
            if (ie && bpriv_reg > r.cur_priv)
            begin
                eval_rsp.int_taken = 1'b1;
                eval_rsp.int_vertical = 1'b1;
            end
            else if (ie && bpriv_reg == r.cur_priv && lvl < blevel_reg)
                eval_rsp.int_taken = 1'b1;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == IdW'(NumInts - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (start) state_next = is_acc ? ST_ACC : ST_SCAN;
            ST_ACC:   if (out_free) state_next = ST_IDLE;
            ST_SCAN:  if (scan_reg == (IdW+1)'(NumInts)) state_next = ST_EN;
            ST_EN:    state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        q_pop = 1'b0;
        unique case (state_reg)
            ST_ACC:  q_pop = out_free;
            ST_DONE: q_pop = out_free;
            default: q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ovalid_reg <= 1'b0;
            scan_reg <= '0;
            clr_reg <= '0;
            best_reg <= '0;
            id_reg <= '0;
            bpriv_reg <= '0;
            blevel_reg <= '0;
            for (int t = 0; t < NumTrigs; t++)
                trig_reg[t] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
                ovalid_reg <= 1'b1;
            else if (out_valid && !out_stall)
                ovalid_reg <= 1'b0;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            // scan init and step; RAM data is registered, so it belongs to the previous scan address
            if (start && !is_acc)
            begin
                scan_reg <= '0;
                best_reg <= '0;
                id_reg <= '0;
                bpriv_reg <= '0;
                blevel_reg <= '0;
            end
            else if (state_reg == ST_SCAN)
            begin
                scan_reg <= scan_reg + 1'b1;
                if (scan_reg != '0 && pend_rd != 8'd0 && key >= best_reg)
                begin
                    best_reg <= key;
                    id_reg <= 12'(scan_reg - 1'b1);
                    bpriv_reg <= key[9:8];
                    blevel_reg <= key[7:0];
                end
            end
            // trigger word writes
            if (trig_we)
                for (int i = 0; i < 4; i++)
                    if (lane_we[i])
                        trig_reg[idx_full[TrigW-1:0]][8*i +: 8] <= lane_wd[i];
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (q_pop)
            rsp_reg <= is_acc ? acc_rsp : eval_rsp;
    end

    assign out_valid = ovalid_reg;
    assign out_data = rsp_reg;

endmodule

FILE: design/clic_interrupt_controller.sv
// Top level of the core-local interrupt controller.
// Depends on clic_pkg, clic_front and clic_back.
//
// Usage:
//   in channel  : in_valid / in_stall / in_data (clic_pkg::req_t). A request
//                 is a register read, register write or an evaluate.
//   out channel : out_valid / out_stall / out_data (clic_pkg::rsp_t), one
//                 result per request, in order.
//   cfg channel : cfg_valid / cfg_ready / cfg_data, writes shv_enabled.
//   A read or write goes through the back-end states ST_IDLE and ST_ACC
//   (registered table RAM read) before out_valid, one request at a time.
//   An evaluate scans one interrupt entry per cycle, then a pipeline step
//   for the registered RAM data, an enable lookup (ST_EN) and the result
//   state (ST_DONE); the next request waits until the evaluate is done.
//   A two-entry queue sits between the front end and the back end, so
//   requests are taken while a scan runs or a result waits.
//   Reset clears trigger words, the queue and shv_enabled; the interrupt
//   table is then cleared entry by entry before the back end starts.
//   When out_stall holds a result, it is kept and the back end neither
//   starts nor ends a request; in_stall rises once the queue is full.
module clic_interrupt_controller (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  clic_pkg::req_t  in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output clic_pkg::rsp_t  out_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic            cfg_data
);
    import clic_pkg::*;

    cmd_t q_data;
    logic q_valid, q_pop;
    logic shv_reg;

    // Configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            shv_reg <= 1'b0;
        else if (cfg_valid)
            shv_reg <= cfg_data;
    end

    clic_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_data   (q_data)
    );

    clic_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .shv_enabled (shv_reg),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_data      (q_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

FILE: tb/testbench.sv
// Testbench for the core-local interrupt controller.
// Drives register and evaluate requests, predicts each result, checks in order.
// Depends on clic_pkg and clic_interrupt_controller.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import clic_pkg::*;

    localparam logic [1:0] ActBad = 2'd3;
    localparam int IdleLimit = 20000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    req_t in_data;
    logic out_valid;
    logic out_stall;
    rsp_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_data;

    // controller state as predicted
    logic       shv_on;
    logic [7:0] pend_q [NumInts];
    logic [7:0] ena_q  [NumInts];
    logic [7:0] attr_q [NumInts];
    logic [7:0] ctl_q  [NumInts];
    logic [31:0] trig_q [NumTrigs];

    rsp_t expected_rsps [$];
    int   errors;
    int   idle_cycles;
    bit   no_idle;       // long stretch with no idling
    bit   hold_req;      // asks the receiver for one long hold-off
    bit   hold_seen;
    int   hold_cycles;

    clic_interrupt_controller DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // register access on the predicted map
    function automatic void model_access(input bit wr, input logic [15:0] addr,
                                         input int len, input logic [31:0] wd,
                                         output logic [31:0] rd, output logic ok);
        int a;
        int idx;
        int lane;
        logic [7:0] b;
        logic [7:0] v;
        a = int'(addr);
        rd = '0;
        ok = 1'b0;
        if (a < TrigBase || (a >= TrigEnd && a < TableBase))
        begin
            ok = !wr;
        end
        else if (a < TrigEnd)
        begin
            idx = (a - TrigBase) >> 2;
            for (int i = 0; i < len; i++)
            begin
                lane = (a & 3) + i;
                if (lane > 3 || idx >= NumTrigs) continue;
                if (wr)
                    trig_q[idx][8*lane +: 8] = wd[8*i +: 8];
                else
                    rd[8*i +: 8] = trig_q[idx][8*lane +: 8];
            end
            ok = 1'b1;
        end
        else if (a < TableEnd)
        begin
            idx = (a - TableBase) >> 2;
            if (!wr && (a & 3) + len > 4) return;
            for (int i = 0; i < len; i++)
            begin
                lane = (a & 3) + i;
                b = wd[8*i +: 8];
                v = '0;
                if (lane > 3 || idx >= NumInts) continue;
                case (lane)
                    0: if (wr) pend_q[idx] = b; else v = pend_q[idx];
                    1: if (wr) ena_q[idx] = b; else v = ena_q[idx];
                    2: if (wr) attr_q[idx] = shv_on ? b : {b[7:1], 1'b0};
                       else v = attr_q[idx];
                    default: if (wr) ctl_q[idx] = b; else v = ctl_q[idx];
                endcase
                if (!wr) rd[8*i +: 8] = v;
            end
            ok = 1'b1;
        end
        else
        begin
            ok = (a + len <= RegionBytes);
        end
    endfunction

    // expected result of one request; updates predicted state
    function automatic rsp_t predict_rsp(input req_t r);
        rsp_t o;
        int best;
        int key;
        int id;
        int mode;
        int lvl;
        logic en;
        logic ie;
        o = '0;
        best = 0;
        id = 0;
        if (r.action == ActRead || r.action == ActWrite)
        begin
            if (r.size_code != 2'd3)
                model_access(r.action == ActWrite, r.address, 1 << r.size_code,
                             r.wdata, o.rdata, o.access_ok);
        end
        else if (r.action == ActEval)
        begin
            for (int i = 0; i < NumInts; i++)
            begin
                if (pend_q[i] != 0)
                begin
                    mode = int'(attr_q[i][7:6]);
                    key = (mode << 8) | int'(ctl_q[i]);
                    if (key >= best)
                    begin
                        best = key;
                        id = i;
                        o.int_priv = 2'(mode);
                        o.int_level = ctl_q[i];
                    end
                end
            end
            o.int_id = 12'(id);
            if (o.int_level != 0)
            begin
                en = ena_q[id] != 0;
                lvl = int'((r.cur_level < r.cur_thresh) ? r.cur_thresh : r.cur_level);
                ie = (r.cur_priv != 2'd2) && r.global_ie && en;
                o.wake = en;
                if (ie && o.int_priv > r.cur_priv)
                begin
                    o.int_taken = 1'b1;
                    o.int_vertical = 1'b1;
                end
                else if (ie && o.int_priv == r.cur_priv && lvl < o.int_level)
                    o.int_taken = 1'b1;
            end
        end
        return o;
    endfunction

    // send one request, idling at random before it
    task automatic send_req(input req_t r);
        while (!no_idle && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_rsps.push_back(predict_rsp(r));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (NumInts + 10) @(posedge clk);
    endtask

    task automatic write_shv(input logic v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        shv_on = v;
    endtask

    function automatic req_t mk_req(input logic [1:0] act, input logic [15:0] addr,
                                    input logic [1:0] sz, input logic [31:0] wd);
        req_t r;
        r = '0;
        r.action = act;
        r.address = addr;
        r.size_code = sz;
        r.wdata = wd;
        return r;
    endfunction

    function automatic req_t rand_eval();
        req_t r;
        r = '0;
        r.action = ActEval;
        r.address = 16'($urandom);
        r.size_code = 2'($urandom);
        r.wdata = $urandom;
        r.cur_priv = 2'($urandom);
        r.cur_level = ($urandom_range(3) == 0) ? 8'($urandom_range(1)*255) : 8'($urandom);
        r.cur_thresh = ($urandom_range(3) == 0) ? 8'($urandom_range(1)*255) : 8'($urandom);
        r.global_ie = 1'($urandom);
        return r;
    endfunction

    // mostly table entries of all interrupts and two absent ones, some triggers and noise
    function automatic req_t rand_access();
        req_t r;
        int pick;
        r = rand_eval();
        r.action = 2'($urandom_range(1));
        r.size_code = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
        pick = $urandom_range(99);
        if (pick < 65)
            r.address = 16'(TableBase + 4*$urandom_range(NumInts + 1) + $urandom_range(3));
        else if (pick < 80)
            r.address = 16'(TrigBase + $urandom_range(TrigEnd - TrigBase - 1));
        else if (pick < 88)
            r.address = 16'($urandom_range(TableBase - 1));
        else if (pick < 94)
            r.address = 16'($urandom_range(16'hFFFF, 16'hFFF8));
        else
            r.address = 16'($urandom);
        return r;
    endfunction

    task automatic test_directed();
        req_t r;
        send_req(rand_eval());                                       // nothing pending on the first pass
        send_req(mk_req(ActWrite, 16'h1000, 2'd2, 32'h05_C1_01_01)); // entry 0
        send_req(mk_req(ActRead, 16'h1000, 2'd2, 32'h0));
        send_req(mk_req(ActWrite, 16'h10FC, 2'd2, 32'hFF_FF_FF_FF)); // entry 63
        send_req(mk_req(ActRead, 16'h10FE, 2'd1, 32'h0));
        send_req(mk_req(ActRead, 16'h1003, 2'd1, 32'h0));            // table crossing read
        send_req(mk_req(ActWrite, 16'h1102, 2'd2, 32'hAB_CD_EF_12)); // crossing write
        send_req(mk_req(ActRead, 16'h1100, 2'd2, 32'h0));            // absent interrupt
        send_req(mk_req(ActWrite, 16'h0040, 2'd2, 32'hDEAD_BEEF));
        send_req(mk_req(ActWrite, 16'h00BD, 2'd2, 32'h1234_5678));   // lane overflow
        send_req(mk_req(ActRead, 16'h00BC, 2'd2, 32'h0));
        send_req(mk_req(ActWrite, 16'h0010, 2'd0, 32'hFF));          // reserved write
        send_req(mk_req(ActRead, 16'h0800, 2'd2, 32'h0));            // custom read
        send_req(mk_req(ActRead, 16'h5000, 2'd2, 32'h0));            // above table
        send_req(mk_req(ActRead, 16'hFFFE, 2'd2, 32'h0));            // past region
        send_req(mk_req(ActWrite, 16'hFFFC, 2'd2, 32'hFFFF_FFFF));
        send_req(mk_req(ActRead, 16'h1000, 2'd3, 32'h0));            // bad size
        r = mk_req(ActBad, 16'h1000, 2'd2, 32'hFFFF_FFFF);           // bad action
        r.cur_level = 8'hFF;
        send_req(r);
        for (int p = 0; p < 4; p++)
        begin
            r = rand_eval();
            r.cur_priv = 2'(p);
            r.global_ie = 1'b1;
            r.cur_level = 8'h00;
            r.cur_thresh = 8'h00;
            send_req(r);
        end
        send_req(mk_req(ActWrite, 16'h10FC, 2'd1, 32'h0000));        // clear pending and enable 63
        send_req(rand_eval());
        wait_drained();
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 15)
                send_req(rand_eval());
            else
                send_req(rand_access());
        end
    endtask

    // receiver holds off while the sender keeps offering requests
    task automatic test_backpressure();
        hold_req = 1'b1;
        test_random(12);
        wait_drained();
    endtask

    // receiver: random stall, plus one counted hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_seen <= 1'b0;
            hold_cycles <= 0;
        end
        else if (hold_req && !hold_seen)
        begin
            hold_seen <= 1'b1;
            hold_cycles <= 150;
            out_stall <= 1'b1;
        end
        else if (hold_cycles != 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= !no_idle && ($urandom_range(99) < 12);
    end

    // result checker
    always @(posedge clk)
    begin
        rsp_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_rsps.size() == 0)
            begin
                $display("%t unexpected result %h", $realtime, out_data);
                errors++;
            end
            else
            begin
                exp_r = expected_rsps.pop_front();
                if (exp_r.rdata !== out_data.rdata)
                begin
                    $display("%t rdata exp %h got %h", $realtime, exp_r.rdata, out_data.rdata);
                    errors++;
                end
                if (exp_r.access_ok !== out_data.access_ok)
                begin
                    $display("%t access_ok exp %b got %b", $realtime,
                             exp_r.access_ok, out_data.access_ok);
                    errors++;
                end
                if (exp_r.int_taken !== out_data.int_taken)
                begin
                    $display("%t int_taken exp %b got %b", $realtime,
                             exp_r.int_taken, out_data.int_taken);
                    errors++;
                end
                if (exp_r.int_vertical !== out_data.int_vertical)
                begin
                    $display("%t int_vertical exp %b got %b", $realtime,
                             exp_r.int_vertical, out_data.int_vertical);
                    errors++;
                end
                if (exp_r.int_id !== out_data.int_id)
                begin
                    $display("%t int_id exp %h got %h", $realtime, exp_r.int_id, out_data.int_id);
                    errors++;
                end
                if (exp_r.int_priv !== out_data.int_priv)
                begin
                    $display("%t int_priv exp %h got %h", $realtime,
                             exp_r.int_priv, out_data.int_priv);
                    errors++;
                end
                if (exp_r.int_level !== out_data.int_level)
                begin
                    $display("%t int_level exp %h got %h", $realtime,
                             exp_r.int_level, out_data.int_level);
                    errors++;
                end
                if (exp_r.wake !== out_data.wake)
                begin
                    $display("%t wake exp %b got %b", $realtime, exp_r.wake, out_data.wake);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted request, result or configuration write
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        shv_on = 1'b0;
        for (int i = 0; i < NumInts; i++)
        begin
            pend_q[i] = '0;
            ena_q[i] = '0;
            attr_q[i] = '0;
            ctl_q[i] = '0;
        end
        for (int i = 0; i < NumTrigs; i++)
            trig_q[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_shv(1'b1);
        test_directed();
        test_random(450);
        wait_drained();
        write_shv(1'b0);
        test_backpressure();
        no_idle = 1'b1;
        test_random(300);
        no_idle = 1'b0;
        wait_drained();
        write_shv(1'b1);
        test_random(650);
        wait_drained();

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
